FILE: rtl/dfst_pkg.sv
// Shared types and constants for the byte-stuffing frame transmitter.
// No dependencies; imported by every module of the block.
package dfst_pkg;

  localparam logic [7:0] FLAG_BYTE    = 8'h7E;
  localparam logic [7:0] ESC_BYTE     = 8'h7D;
  localparam logic [7:0] ESC_XOR      = 8'h20;
  localparam logic [7:0] ADDR_RESET   = 8'h03;

  // One classified payload word, as handed from the front end to the back end.
  typedef struct packed {
    logic       hdr;      // frame opens with this word: send the header first
    logic       seq;      // sequence bit for the control byte
    logic       esc;      // word is stuffed: escape byte, then data_val
    logic       last;     // word closes the frame: check byte and flag follow
    logic [7:0] addr;     // address byte for the header
    logic [7:0] data_val; // payload byte as sent (already XORed when stuffed)
    logic [7:0] parity;   // running XOR of the frame, valid when last is set
  } dfst_cmd_t;

endpackage

FILE: rtl/dfst_front.sv
// Front end: accepts payload words, keeps the frame state and classifies each word.
// Depends on dfst_pkg; feeds dfst_fifo.
module dfst_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_wr_en,
  input  logic [7:0]          cfg_wr_data,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [7:0]          in_data,
  input  logic                in_last,
  input  logic                q_full,
  output logic                q_push,
  output dfst_pkg::dfst_cmd_t q_cmd
);
  import dfst_pkg::*;

  logic       in_frame;
  logic       seq_bit;
  logic [7:0] parity_acc;
  logic [7:0] address_byte;
  logic [7:0] parity_next;
  logic       stuff;

  assign in_ready = !q_full;
  assign q_push   = in_valid && !q_full;

  // A new frame restarts the check byte from this word.
  assign parity_next = (in_frame ? parity_acc : 8'h00) ^ in_data;
  assign stuff       = (in_data == FLAG_BYTE) || (in_data == ESC_BYTE);

  always_comb begin
    q_cmd.hdr      = !in_frame;
    q_cmd.seq      = seq_bit;
    q_cmd.esc      = stuff;
    q_cmd.last     = in_last;
    q_cmd.addr     = address_byte;
    q_cmd.data_val = stuff ? (in_data ^ ESC_XOR) : in_data;
    q_cmd.parity   = parity_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_frame     <= 1'b0;
      seq_bit      <= 1'b0;
      parity_acc   <= 8'h00;
      address_byte <= ADDR_RESET;
    end else begin
      if (cfg_wr_en) begin
        address_byte <= cfg_wr_data;
      end
      if (q_push) begin
        if (in_last) begin
          in_frame   <= 1'b0;
          seq_bit    <= ~seq_bit;
          parity_acc <= 8'h00;
        end else begin
          in_frame   <= 1'b1;
          parity_acc <= parity_next;
        end
      end
    end
  end

endmodule

FILE: rtl/dfst_fifo.sv
// Short command queue between the front and back ends.
// Depends on dfst_pkg for the entry type.
module dfst_fifo #(
  parameter int DEPTH = 4
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  dfst_pkg::dfst_cmd_t push_cmd,
  input  logic                pop,
  output logic                full,
  output logic                not_empty,
  output dfst_pkg::dfst_cmd_t head
);
  import dfst_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  dfst_cmd_t          entries [DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_W-1:0]   count;
  logic               do_push;
  logic               do_pop;

  assign full      = (count == CNT_W'(DEPTH));
  assign not_empty = (count != '0);
  assign head      = entries[rd_ptr];
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

FILE: rtl/dfst_back.sv
// Back end: walks each queued command through header, payload and trailer bytes.
// Depends on dfst_pkg; drives the registered output stream.
module dfst_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                cmd_valid,
  input  dfst_pkg::dfst_cmd_t cmd,
  output logic                cmd_pop,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [7:0]          out_byte,
  output logic                out_frame_end,
  output logic                out_run_last
);
  import dfst_pkg::*;

  typedef enum logic [7:0] {
    ST_START = 8'b0000_0001,
    ST_ADDR  = 8'b0000_0010,
    ST_CTRL  = 8'b0000_0100,
    ST_HCHK  = 8'b0000_1000,
    ST_ESC   = 8'b0001_0000,
    ST_DATA  = 8'b0010_0000,
    ST_CHECK = 8'b0100_0000,
    ST_CLOSE = 8'b1000_0000
  } step_t;

  step_t      step;
  step_t      step_next;
  logic [7:0] byte_sel;
  logic       end_sel;
  logic       final_sel;
  logic       load;
  logic [7:0] ctrl_byte;

  assign ctrl_byte = {7'b0, cmd.seq};
  assign load      = cmd_valid && (!out_valid || out_ready);
  assign cmd_pop   = load && final_sel;

  always_comb begin
    byte_sel  = cmd.data_val;
    end_sel   = 1'b0;
    final_sel = 1'b0;
    step_next = ST_START;
    unique case (step)
      ST_START: begin
        if (cmd.hdr) begin
          byte_sel  = FLAG_BYTE;
          step_next = ST_ADDR;
        end else if (cmd.esc) begin
          byte_sel  = ESC_BYTE;
          step_next = ST_DATA;
        end else begin
          byte_sel  = cmd.data_val;
          final_sel = !cmd.last;
          step_next = cmd.last ? ST_CHECK : ST_START;
        end
      end
      ST_ADDR: begin
        byte_sel  = cmd.addr;
        step_next = ST_CTRL;
      end
      ST_CTRL: begin
        byte_sel  = ctrl_byte;
        step_next = ST_HCHK;
      end
      ST_HCHK: begin
        byte_sel  = cmd.addr ^ ctrl_byte;
        step_next = cmd.esc ? ST_ESC : ST_DATA;
      end
      ST_ESC: begin
        byte_sel  = ESC_BYTE;
        step_next = ST_DATA;
      end
      ST_DATA: begin
        byte_sel  = cmd.data_val;
        final_sel = !cmd.last;
        step_next = cmd.last ? ST_CHECK : ST_START;
      end
      ST_CHECK: begin
        byte_sel  = cmd.parity;
        step_next = ST_CLOSE;
      end
      ST_CLOSE: begin
        byte_sel  = FLAG_BYTE;
        end_sel   = 1'b1;
        final_sel = 1'b1;
        step_next = ST_START;
      end
      default: begin
        step_next = ST_START;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_byte      <= byte_sel;
      out_frame_end <= end_sel;
      out_run_last  <= final_sel;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step      <= ST_START;
      out_valid <= 1'b0;
    end else begin
      if (load) begin
        step      <= step_next;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

FILE: rtl/data_frame_stuffing_transmitter.sv
// Byte-stuffing frame transmitter: header, stuffed payload, check byte and closing flag.
// An accepted word is queued, then the back end registers its output bytes.
// Throughput: one output word per cycle while m_axis_tready is high; a payload word makes
// 1 to 8 bytes (1 plain, 2 stuffed, plus 4 for a frame header and 2 for a frame trailer).
// The output sequencer sets the pace; the command queue absorbs bursts of FIFO_DEPTH words.
// Reset (rst, synchronous) empties the queue and output, closes any open frame,
// clears the sequence bit and loads the address register with 0x03.
module data_frame_stuffing_transmitter #(
  parameter int FIFO_DEPTH = 4
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_wr_en,
  input  logic [7:0] cfg_wr_data,    // address_byte
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] data_byte
  input  logic       s_axis_tlast,   // last_byte
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [7:0] out_byte
  output logic       m_axis_tlast,   // frame_end
  output logic [0:0] m_axis_tuser    // [0] run_last
);
  import dfst_pkg::*;

  dfst_cmd_t push_cmd;
  dfst_cmd_t head_cmd;
  logic      push;
  logic      pop;
  logic      q_full;
  logic      q_not_empty;
  logic      run_last;

  dfst_front u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (s_axis_tvalid),
    .in_ready    (s_axis_tready),
    .in_data     (s_axis_tdata),
    .in_last     (s_axis_tlast),
    .q_full      (q_full),
    .q_push      (push),
    .q_cmd       (push_cmd)
  );

  dfst_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_cmd  (push_cmd),
    .pop       (pop),
    .full      (q_full),
    .not_empty (q_not_empty),
    .head      (head_cmd)
  );

  dfst_back u_back (
    .clk           (clk),
    .rst           (rst),
    .cmd_valid     (q_not_empty),
    .cmd           (head_cmd),
    .cmd_pop       (pop),
    .out_valid     (m_axis_tvalid),
    .out_ready     (m_axis_tready),
    .out_byte      (m_axis_tdata),
    .out_frame_end (m_axis_tlast),
    .out_run_last  (run_last)
  );

  assign m_axis_tuser = run_last;

endmodule

FILE: rtl/dfst_checker.sv
// Port-level checks on the transmitter's output stream, bound to the top level.
// Depends on dfst_pkg for the flag byte.
module dfst_checker (
  input logic       clk,
  input logic       rst,
  input logic       m_axis_tvalid,
  input logic       m_axis_tready,
  input logic [7:0] m_axis_tdata,
  input logic       m_axis_tlast,
  input logic [0:0] m_axis_tuser
);
  import dfst_pkg::*;

  // Reset leaves no word pending on the output.
  a_reset_idle: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("output valid after reset");

  // A closing flag always ends the run of words caused by its input word.
  a_end_is_run_last: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tlast |-> m_axis_tuser[0])
    else $error("frame end without run end");

  // The frame end mark only ever sits on a flag byte.
  a_end_is_flag: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tlast |-> m_axis_tdata == FLAG_BYTE)
    else $error("frame end on a non-flag byte");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)
      && $stable(m_axis_tuser))
    else $error("output word changed while stalled");

endmodule

bind data_frame_stuffing_transmitter dfst_checker u_dfst_checker (.*);

FILE: dv/tb_data_frame_stuffing_transmitter.sv
`timescale 1ns / 1ps
// Self-checking testbench for data_frame_stuffing_transmitter: directed and random frames
// under random gaps on both streams, checked word by word against a built-in frame builder.
// Depends on rtl/dfst_pkg.sv and rtl/data_frame_stuffing_transmitter.sv.
module tb_data_frame_stuffing_transmitter;
  import dfst_pkg::*;

  localparam int WATCHDOG_CYCLES = 1000;
  localparam int SETTLE_CYCLES   = 12;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } payload_word_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       frame_end;
    logic       run_last;
  } line_word_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       cfg_wr_en = 1'b0;
  logic [7:0] cfg_wr_data = 8'h00;
  logic       s_axis_tvalid = 1'b0;
  logic       s_axis_tready;
  logic [7:0] s_axis_tdata = 8'h00;   // [7:0] data_byte
  logic       s_axis_tlast = 1'b0;    // last_byte
  logic       m_axis_tvalid;
  logic       m_axis_tready = 1'b0;
  logic [7:0] m_axis_tdata;           // [7:0] out_byte
  logic       m_axis_tlast;           // frame_end
  logic [0:0] m_axis_tuser;           // [0] run_last

  data_frame_stuffing_transmitter dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  payload_word_t payload_pending[$];
  line_word_t    line_expected[$];

  // Framer state as the block should hold it.
  logic [7:0] tx_addr = ADDR_RESET;
  logic       tx_in_frame = 1'b0;
  logic       tx_seq = 1'b0;
  logic [7:0] tx_parity = 8'h00;

  int  err_cnt = 0;
  int  gap_in = 0;
  int  hold_out = 0;
  int  idle_cycles = 0;
  bit  no_idle = 1'b0;

  function automatic int idle_len();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Appends the line words that one accepted payload word produces.
  task automatic frame_payload_word(input logic [7:0] d, input logic l);
    logic [7:0] b[8];
    int n;
    int i;
    n = 0;
    if (!tx_in_frame) begin
      b[0] = FLAG_BYTE;
      b[1] = tx_addr;
      b[2] = {7'd0, tx_seq};
      b[3] = tx_addr ^ {7'd0, tx_seq};
      n = 4;
      tx_parity = 8'h00;
      tx_in_frame = 1'b1;
    end
    tx_parity = tx_parity ^ d;
    if (d == FLAG_BYTE || d == ESC_BYTE) begin
      b[n] = ESC_BYTE;
      b[n + 1] = d ^ ESC_XOR;
      n = n + 2;
    end else begin
      b[n] = d;
      n = n + 1;
    end
    // The check byte goes out raw, even when it matches a flag or escape.
    if (l) begin
      b[n] = tx_parity;
      b[n + 1] = FLAG_BYTE;
      n = n + 2;
      tx_seq = ~tx_seq;
      tx_in_frame = 1'b0;
    end
    for (i = 0; i < n; i++) begin
      line_expected.push_back('{out_byte: b[i], frame_end: l && (i == n - 1),
                                run_last: (i == n - 1)});
    end
  endtask

  // Input side: presents queued words with random gaps between them.
  always @(posedge clk) begin : payload_driver
    payload_word_t w;
    if (rst) begin
      s_axis_tvalid <= 1'b0;
      gap_in <= 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        frame_payload_word(s_axis_tdata, s_axis_tlast);
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (gap_in > 0) begin
          gap_in <= gap_in - 1;
          s_axis_tvalid <= 1'b0;
        end else if (payload_pending.size() > 0) begin
          w = payload_pending.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata <= w.data;
          s_axis_tlast <= w.last;
          gap_in <= idle_len();
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Output side: random back-pressure and the word-by-word comparison.
  always @(posedge clk) begin : line_monitor
    line_word_t exp_w;
    int stall;
    if (rst) begin
      m_axis_tready <= 1'b0;
      hold_out <= 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (line_expected.size() == 0) begin
          $error("unexpected word: out_byte %h frame_end %b run_last %b",
                 m_axis_tdata, m_axis_tlast, m_axis_tuser[0]);
          err_cnt = err_cnt + 1;
        end else begin
          exp_w = line_expected.pop_front();
          if (m_axis_tdata !== exp_w.out_byte) begin
            $error("out_byte: expected %h, got %h", exp_w.out_byte, m_axis_tdata);
            err_cnt = err_cnt + 1;
          end
          if (m_axis_tlast !== exp_w.frame_end) begin
            $error("frame_end: expected %b, got %b", exp_w.frame_end, m_axis_tlast);
            err_cnt = err_cnt + 1;
          end
          if (m_axis_tuser[0] !== exp_w.run_last) begin
            $error("run_last: expected %b, got %b", exp_w.run_last, m_axis_tuser[0]);
            err_cnt = err_cnt + 1;
          end
        end
      end
      if (hold_out > 0) begin
        hold_out <= hold_out - 1;
        m_axis_tready <= 1'b0;
      end else begin
        stall = idle_len();
        if (stall == 0) begin
          m_axis_tready <= 1'b1;
        end else begin
          m_axis_tready <= 1'b0;
          hold_out <= stall - 1;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_CYCLES) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic queue_word(input logic [7:0] d, input logic l);
    payload_word_t w;
    w.data = d;
    w.last = l;
    payload_pending.push_back(w);
  endtask

  task automatic write_address(input logic [7:0] a);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= a;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    tx_addr = a;
  endtask

  // Waits until the block has sent everything owed, then a quiet settling period.
  task automatic drain();
    do @(negedge clk);
    while (payload_pending.size() != 0 || s_axis_tvalid || line_expected.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  function automatic logic [7:0] pick_byte();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return FLAG_BYTE;
    if (r == 1) return ESC_BYTE;
    if (r == 2) return ($urandom_range(0, 1) != 0) ? (FLAG_BYTE ^ ESC_XOR) : (ESC_BYTE ^ ESC_XOR);
    return 8'($urandom_range(0, 255));
  endfunction

  // Whole frames, mostly short, until n_items payload words are queued.
  task automatic queue_random_frames(input int n_items);
    int len;
    int r;
    int k;
    while (n_items > 0) begin
      r = $urandom_range(0, 99);
      if (r < 60) len = $urandom_range(1, 4);
      else if (r < 90) len = $urandom_range(5, 12);
      else len = $urandom_range(13, 30);
      if (len > n_items) len = n_items;
      for (k = 0; k < len; k++) begin
        queue_word(pick_byte(), k == len - 1);
      end
      n_items = n_items - len;
    end
  endtask

  initial begin
    int p;
    logic [7:0] a;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Reset address; single-word frames whose only word needs stuffing,
    // then a frame that walks the stuffing boundaries.
    queue_word(FLAG_BYTE, 1'b1);
    queue_word(ESC_BYTE, 1'b1);
    queue_word(8'h00, 1'b0);
    queue_word(8'hFF, 1'b0);
    queue_word(FLAG_BYTE, 1'b0);
    queue_word(ESC_BYTE, 1'b0);
    queue_word(FLAG_BYTE ^ ESC_XOR, 1'b0);
    queue_word(ESC_BYTE ^ ESC_XOR, 1'b0);
    queue_word(ESC_XOR, 1'b1);
    drain();

    // Header and check words that equal the flag or escape go out unstuffed.
    write_address(FLAG_BYTE);
    queue_word(FLAG_BYTE, 1'b0);
    queue_word(8'h00, 1'b1);
    queue_word(ESC_BYTE, 1'b1);
    drain();
    write_address(ESC_BYTE);
    queue_word(8'h11, 1'b0);
    queue_word(8'h6C, 1'b1);
    drain();
    write_address(8'h00);
    queue_word(8'hFF, 1'b1);
    drain();
    write_address(8'hFF);
    queue_word(8'h00, 1'b1);
    drain();

    for (p = 0; p < 6; p++) begin
      if (p == 0) a = 8'h00;
      else if (p == 1) a = 8'hFF;
      else if (p == 4) a = FLAG_BYTE;
      else a = 8'($urandom_range(0, 255));
      no_idle = (p == 2);
      write_address(a);
      queue_random_frames(62);
      drain();
    end

    if (err_cnt == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/dfst_pkg.sv
rtl/dfst_front.sv
rtl/dfst_fifo.sv
rtl/dfst_back.sv
rtl/data_frame_stuffing_transmitter.sv
rtl/dfst_checker.sv
dv/tb_data_frame_stuffing_transmitter.sv
